// ----- hw/rtl/wmtf_pkg.sv -----
// ----------------------------------------------------------------------------
// wmtf_pkg
// Shared constants and control structs of the move-to-front word decoder.
// ----------------------------------------------------------------------------
package wmtf_pkg;

    localparam logic [7:0] CH_0  = 8'h30;
    localparam logic [7:0] CH_9  = 8'h39;
    localparam logic [7:0] CH_LA = 8'h61;
    localparam logic [7:0] CH_LZ = 8'h7A;
    localparam logic [7:0] CH_UA = 8'h41;
    localparam logic [7:0] CH_UZ = 8'h5A;
    localparam logic [3:0] RADIX = 4'd10;

    localparam int         ACC_W   = 9;
    localparam logic [8:0] ACC_MAX = 9'd511;
    localparam int         LEN_W   = 6;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_TRUNC = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic latch_in;
        logic acc_update;
        logic acc_clear;
        logic ord_rd_pos;
        logic ord_rd_tail;
        logic ord_rd_shift;
        logic ord_wr_shift;
        logic ord_wr_front;
        logic phys_from_ord;
        logic len_rd;
        logic len_capture;
        logic byte_rd;
        logic k_inc;
        logic tgt_from_count;
        logic tgt_from_ord;
        logic store_letter;
        logic close_begin;
        logic out_word;
        logic out_char;
        logic out_range;
        logic out_empty;
        logic out_last;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic letter;
        logic digit;
        logic eol;
        logic acc_zero;
        logic acc_over;
        logic pending_zero;
        logic full;
        logic sh_zero;
        logic k_last;
        logic out_free;
    } stat_t;

endpackage

// ----- hw/rtl/wmtf_ram.sv -----
// ----------------------------------------------------------------------------
// wmtf_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module wmtf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/wmtf_dpath.sv -----
// ----------------------------------------------------------------------------
// wmtf_dpath
// Word store, order list, length table, counters and result register.
// ----------------------------------------------------------------------------
module wmtf_dpath #(
    parameter int TABLE_WORDS = 256,
    parameter int WORD_BYTES  = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  wmtf_pkg::cmd_t      cmd,
    output wmtf_pkg::stat_t     stat,
    input  logic [7:0]          in_byte,
    input  logic                in_eol,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [7:0]          out_byte,
    output logic                out_byte_valid,
    output logic                out_run_last,
    output logic                out_line_done,
    output logic [1:0]          out_status
);

    localparam int IW = $clog2(TABLE_WORDS);
    localparam int CW = IW + 1;
    localparam int SW = (WORD_BYTES > 1) ? $clog2(WORD_BYTES) : 1;
    localparam int NW = (CW > wmtf_pkg::ACC_W) ? CW : wmtf_pkg::ACC_W;
    localparam int LW = wmtf_pkg::LEN_W;

    logic [7:0]                  byte_reg;
    logic                        eol_reg;
    logic [wmtf_pkg::ACC_W-1:0]  acc_reg;
    logic [CW-1:0]               count_reg;
    logic [LW-1:0]               pending_reg;
    logic [IW-1:0]               tgt_reg;
    logic [IW-1:0]               ins_reg;
    logic [IW-1:0]               sh_reg;
    logic [LW-1:0]               k_reg;
    logic [LW-1:0]               len_reg;
    logic                        trunc_reg;
    logic                        ovalid_reg;
    logic [7:0]                  obyte_reg;
    logic                        obv_reg;
    logic                        olast_reg;
    logic                        oline_reg;
    logic [1:0]                  ostat_reg;

    logic [IW-1:0]               ord_rdata;
    logic [LW-1:0]               len_rdata;
    logic [7:0]                  byte_rdata;
    logic                        ord_re;
    logic [IW-1:0]               ord_raddr;
    logic                        ord_we;
    logic [IW-1:0]               ord_waddr;
    logic [IW-1:0]               ord_wdata;
    logic [IW-1:0]               pos;
    logic [IW-1:0]               upto;
    logic                        full;
    logic                        room;
    logic [13:0]                 acc_next;
    logic                        load;

    assign full = count_reg == CW'(TABLE_WORDS);
    assign room = pending_reg != LW'(WORD_BYTES);
    assign pos  = IW'(acc_reg - 9'd1);
    assign upto = full ? IW'(TABLE_WORDS - 1) : count_reg[IW-1:0];
    assign acc_next = 14'({acc_reg, 3'b000}) + 14'({acc_reg, 1'b0})
                    + 14'(byte_reg - wmtf_pkg::CH_0);

    assign ord_re    = cmd.ord_rd_pos | cmd.ord_rd_tail | cmd.ord_rd_shift;
    assign ord_raddr = cmd.ord_rd_pos  ? pos :
                       cmd.ord_rd_tail ? IW'(TABLE_WORDS - 1) : sh_reg - IW'(1);
    assign ord_we    = cmd.ord_wr_shift | cmd.ord_wr_front;
    assign ord_waddr = cmd.ord_wr_front ? '0 : sh_reg;
    assign ord_wdata = cmd.ord_wr_front ? ins_reg : ord_rdata;

    wmtf_ram #(.WIDTH(IW), .DEPTH(TABLE_WORDS)) u_order (
        .aclk  (aclk),
        .we    (ord_we),
        .waddr (ord_waddr),
        .wdata (ord_wdata),
        .re    (ord_re),
        .raddr (ord_raddr),
        .rdata (ord_rdata)
    );

    wmtf_ram #(.WIDTH(LW), .DEPTH(TABLE_WORDS)) u_len (
        .aclk  (aclk),
        .we    (cmd.close_begin),
        .waddr (tgt_reg),
        .wdata (pending_reg),
        .re    (cmd.len_rd),
        .raddr (ins_reg),
        .rdata (len_rdata)
    );

    wmtf_ram #(.WIDTH(8), .DEPTH(TABLE_WORDS << SW)) u_store (
        .aclk  (aclk),
        .we    (cmd.store_letter & room),
        .waddr ({tgt_reg, pending_reg[SW-1:0]}),
        .wdata (byte_reg),
        .re    (cmd.byte_rd),
        .raddr ({ins_reg, k_reg[SW-1:0]}),
        .rdata (byte_rdata)
    );

    assign load = cmd.out_word | cmd.out_char | cmd.out_range | cmd.out_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg     <= '0;
            count_reg   <= '0;
            pending_reg <= '0;
            ovalid_reg  <= 1'b0;
        end else begin
            if (cmd.acc_clear) begin
                acc_reg <= '0;
            end else if (cmd.acc_update) begin
                acc_reg <= (acc_next > 14'(wmtf_pkg::ACC_MAX)) ? wmtf_pkg::ACC_MAX
                                                               : acc_next[8:0];
            end
            if (cmd.store_letter && room) begin
                pending_reg <= pending_reg + LW'(1);
            end else if (cmd.close_begin) begin
                pending_reg <= '0;
            end
            if (cmd.close_begin && !full) begin
                count_reg <= count_reg + CW'(1);
            end
            if (load) begin
                ovalid_reg <= 1'b1;
            end else if (out_ready) begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            byte_reg <= in_byte;
            eol_reg  <= in_eol;
        end
        if (cmd.ord_rd_pos) begin
            sh_reg <= pos;
        end else if (cmd.close_begin) begin
            sh_reg <= upto;
        end else if (cmd.ord_wr_shift) begin
            sh_reg <= sh_reg - IW'(1);
        end
        if (cmd.phys_from_ord) begin
            ins_reg <= ord_rdata;
        end else if (cmd.close_begin) begin
            ins_reg <= tgt_reg;
        end
        if (cmd.tgt_from_count) begin
            tgt_reg <= count_reg[IW-1:0];
        end else if (cmd.tgt_from_ord) begin
            tgt_reg <= ord_rdata;
        end
        if (cmd.len_capture) begin
            len_reg <= len_rdata;
            k_reg   <= '0;
        end else if (cmd.k_inc) begin
            k_reg <= k_reg + LW'(1);
        end
        // drop the truncation mark with every new request
        if (cmd.latch_in) begin
            trunc_reg <= 1'b0;
        end else if (cmd.store_letter) begin
            trunc_reg <= !room;
        end
        if (load) begin
            olast_reg <= cmd.out_last;
            oline_reg <= cmd.out_last & eol_reg;
            if (cmd.out_word) begin
                obyte_reg <= byte_rdata;
                obv_reg   <= 1'b1;
                ostat_reg <= wmtf_pkg::ST_OK;
            end else if (cmd.out_char) begin
                obyte_reg <= byte_reg;
                obv_reg   <= 1'b1;
                ostat_reg <= trunc_reg ? wmtf_pkg::ST_TRUNC : wmtf_pkg::ST_OK;
            end else begin
                obyte_reg <= '0;
                obv_reg   <= 1'b0;
                ostat_reg <= cmd.out_range ? wmtf_pkg::ST_RANGE : wmtf_pkg::ST_OK;
            end
        end
    end

    always_comb begin
        stat.letter       = (byte_reg inside {[wmtf_pkg::CH_LA:wmtf_pkg::CH_LZ],
                                              [wmtf_pkg::CH_UA:wmtf_pkg::CH_UZ]});
        stat.digit        = (byte_reg inside {[wmtf_pkg::CH_0:wmtf_pkg::CH_9]});
        stat.eol          = eol_reg;
        stat.acc_zero     = acc_reg == '0;
        stat.acc_over     = NW'(acc_reg) > NW'(count_reg);
        stat.pending_zero = pending_reg == '0;
        stat.full         = full;
        stat.sh_zero      = sh_reg == '0;
        stat.k_last       = (k_reg + LW'(1)) == len_reg;
        stat.out_free     = !ovalid_reg | out_ready;
    end

    assign out_valid      = ovalid_reg;
    assign out_byte       = obyte_reg;
    assign out_byte_valid = obv_reg;
    assign out_run_last   = olast_reg;
    assign out_line_done  = oline_reg;
    assign out_status     = ostat_reg;

endmodule

// ----- hw/rtl/wmtf_ctrl.sv -----
// ----------------------------------------------------------------------------
// wmtf_ctrl
// Sequencer: close word, accumulate digits, resolve index, move to front.
// ----------------------------------------------------------------------------
module wmtf_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  wmtf_pkg::stat_t stat,
    output wmtf_pkg::cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_CLOSE1, S_ACC, S_RES, S_R_ORD, S_R_LEN, S_R_LCAP, S_R_BRD,
        S_R_BOUT, S_LETTER, S_L_TAIL, S_L_WRITE, S_CHAR, S_CLOSE2, S_EMPTY,
        S_SH_RD, S_SH_WR
    } state_t;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;
    state_t after_close1, after_res, after_char;

    always_comb begin
        after_close1 = stat.letter ? S_RES : (stat.digit ? S_ACC : S_RES);
        after_res    = stat.letter ? S_LETTER : (stat.digit ? S_IDLE : S_CHAR);
        after_char   = (stat.letter && stat.eol) ? S_CLOSE2 : S_IDLE;
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        ret_next   = ret_reg;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_CLOSE1;
                end
            end
            S_CLOSE1, S_CLOSE2: begin
                if (state_reg == S_CLOSE1 && stat.letter) begin
                    state_next = S_RES;
                end else if (stat.pending_zero) begin
                    state_next = (state_reg == S_CLOSE1) ? after_close1 : S_IDLE;
                end else begin
                    cmd.close_begin = 1'b1;
                    ret_next   = (state_reg == S_CLOSE1) ? after_close1 : S_IDLE;
                    state_next = S_SH_RD;
                end
            end
            S_ACC: begin
                cmd.acc_update = 1'b1;
                state_next     = stat.eol ? S_RES : S_IDLE;
            end
            S_RES: begin
                if (stat.acc_zero) begin
                    state_next = stat.digit ? S_EMPTY : after_res;
                end else if (stat.acc_over) begin
                    if (stat.out_free) begin
                        cmd.out_range = 1'b1;
                        cmd.out_last  = stat.digit;
                        cmd.acc_clear = 1'b1;
                        state_next    = after_res;
                    end
                end else begin
                    cmd.ord_rd_pos = 1'b1;
                    cmd.acc_clear  = 1'b1;
                    ret_next       = after_res;
                    state_next     = S_R_ORD;
                end
            end
            S_R_ORD: begin
                cmd.phys_from_ord = 1'b1;
                state_next        = S_R_LEN;
            end
            S_R_LEN: begin
                cmd.len_rd = 1'b1;
                state_next = S_R_LCAP;
            end
            S_R_LCAP: begin
                cmd.len_capture = 1'b1;
                state_next      = S_R_BRD;
            end
            S_R_BRD: begin
                cmd.byte_rd = 1'b1;
                state_next  = S_R_BOUT;
            end
            S_R_BOUT: begin
                if (stat.out_free) begin
                    cmd.out_word = 1'b1;
                    cmd.out_last = stat.digit & stat.k_last;
                    cmd.k_inc    = 1'b1;
                    state_next   = stat.k_last ? S_SH_RD : S_R_BRD;
                end
            end
            S_LETTER: begin
                if (!stat.pending_zero) begin
                    state_next = S_L_WRITE;
                end else if (stat.full) begin
                    cmd.ord_rd_tail = 1'b1;
                    state_next      = S_L_TAIL;
                end else begin
                    cmd.tgt_from_count = 1'b1;
                    state_next         = S_L_WRITE;
                end
            end
            S_L_TAIL: begin
                cmd.tgt_from_ord = 1'b1;
                state_next       = S_L_WRITE;
            end
            S_L_WRITE: begin
                cmd.store_letter = 1'b1;
                state_next       = S_CHAR;
            end
            S_CHAR: begin
                if (stat.out_free) begin
                    cmd.out_char = 1'b1;
                    cmd.out_last = 1'b1;
                    state_next   = after_char;
                end
            end
            S_EMPTY: begin
                if (stat.out_free) begin
                    cmd.out_empty = 1'b1;
                    cmd.out_last  = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_SH_RD: begin
                if (stat.sh_zero) begin
                    cmd.ord_wr_front = 1'b1;
                    state_next       = ret_reg;
                end else begin
                    cmd.ord_rd_shift = 1'b1;
                    state_next       = S_SH_WR;
                end
            end
            S_SH_WR: begin
                cmd.ord_wr_shift = 1'b1;
                state_next       = S_SH_RD;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

endmodule

// ----- hw/rtl/word_move_to_front_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// word_move_to_front_decoder_unit
// Move-to-front word decoder: expands index references into recent words.
// ----------------------------------------------------------------------------
// One text byte is taken per request, with s_tlast marking the end of a line.
// Letters pass straight through and are collected into a word; digit runs form
// an index that, once the run ends, is replaced by the n-th most recent word,
// which then moves to the front of the recency list. The word table persists
// across lines. Words live in fixed slots and never move; recency is an order
// list of slot numbers held in RAM, so a move to the front shifts that list
// one entry at a time, each by a read and then a write. A new word in a full
// table takes the least recent slot. Results leave through a one-deep output
// register, so a finished result may wait for m_tready while the next
// request is taken. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module word_move_to_front_decoder_unit #(
    parameter int TABLE_WORDS = 256,
    parameter int WORD_BYTES  = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] text_byte
    input  logic       s_tlast,   // line_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [3:0] m_tuser,   // [0] byte_valid, [1] run_last, [3:2] status
    output logic       m_tlast    // line_done
);

    wmtf_pkg::cmd_t  cmd;
    wmtf_pkg::stat_t stat;
    logic            byte_valid;
    logic            run_last;
    logic [1:0]      status;

    // Sequence each request through close, accumulate, resolve and emit.
    wmtf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Hold the tables, counters and the output register.
    wmtf_dpath #(
        .TABLE_WORDS (TABLE_WORDS),
        .WORD_BYTES  (WORD_BYTES)
    ) u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .in_byte        (s_tdata),
        .in_eol         (s_tlast),
        .out_ready      (m_tready),
        .out_valid      (m_tvalid),
        .out_byte       (m_tdata),
        .out_byte_valid (byte_valid),
        .out_run_last   (run_last),
        .out_line_done  (m_tlast),
        .out_status     (status)
    );

    assign m_tuser = {status, run_last, byte_valid};

    // A line ends only on the last result of a request.
    a_line_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser[1])
        else $error("line_done without run_last");

    // Status-only results carry a zero byte.
    a_status_only_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == 8'd0)
        else $error("status-only result with data");

    // Truncation is only reported on a passed-through letter.
    a_trunc_has_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[3:2] == wmtf_pkg::ST_TRUNC |-> m_tuser[0])
        else $error("truncation status without byte");

    // Out-of-range results never carry a byte.
    a_range_no_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[3:2] == wmtf_pkg::ST_RANGE |-> !m_tuser[0])
        else $error("range status with byte");

endmodule
